@@ rtl/fir_convolution_reverb_macros.svh @@
// Assertion macros shared by the checker of the convolution reverb block.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
// Each macro expands to one labeled concurrent assertion that reports with $error.
`ifndef FIR_CONVOLUTION_REVERB_MACROS_SVH
`define FIR_CONVOLUTION_REVERB_MACROS_SVH

// Same-cycle implication.
`define FCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fcr_pkg.sv @@
// Shared types and constants of the convolution reverb block.
// Used by fcr_mac, fir_convolution_reverb, fcr_checker and the testbench files; depends on nothing.
package fcr_pkg;

    localparam int MAX_TAPS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TAPS_W          = 11;
    localparam int ACC_W           = 64;

    localparam logic [TAPS_W-1:0] TAPS_RESET = 11'd1024;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [9:0]         tap_index;
        logic signed [15:0] tap_value;
        logic signed [15:0] sample_in;
    } req_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               clipped;
    } rsp_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clr;
        logic vld;
    } mac_ctl_t;

endpackage

@@ rtl/fcr_mac.sv @@
// Shared multiply-accumulate unit with round-half-up and saturation of the sum.
// Depends on fcr_pkg for the control struct, the result type and the accumulator width.
module fcr_mac #(
    parameter int SAMPLE_BITS = fcr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fcr_pkg::mac_ctl_t      ctl,
    input  logic [SAMPLE_BITS-1:0] coef,
    input  logic [SAMPLE_BITS-1:0] samp,
    output logic                   busy,
    output fcr_pkg::rsp_t          result
);

    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int AW   = fcr_pkg::ACC_W;
    localparam logic signed [AW-1:0] HALF   = AW'(64'sd1 <<< (FRAC - 1));
    localparam logic signed [AW-1:0] MAXPOS = AW'((64'sd1 <<< FRAC) - 64'sd1);
    localparam logic signed [AW-1:0] MAXNEG = AW'(-(64'sd1 <<< FRAC));

    logic signed [2*SAMPLE_BITS-1:0] prod_reg;
    logic                            prod_vld_reg;
    logic signed [AW-1:0]            acc_reg;
    logic signed [AW-1:0]            rnd;
    logic signed [AW-1:0]            quo;
    logic signed [AW-1:0]            res;
    logic                            clip;

    always_ff @(posedge clk)
    begin
        if (ctl.vld)
        begin
            prod_reg <= $signed(coef) * $signed(samp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctl.vld;
            if (ctl.clr)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
        end
    end

    // Adding half an LSB and shifting arithmetically floors toward minus infinity,
    // which is round half up for both signs.
    always_comb
    begin
        rnd  = acc_reg + HALF;
        quo  = rnd >>> FRAC;
        clip = 1'b0;
        res  = quo;
        if (quo > MAXPOS)
        begin
            res  = MAXPOS;
            clip = 1'b1;
        end
        else if (quo < MAXNEG)
        begin
            res  = MAXNEG;
            clip = 1'b1;
        end
    end

    assign busy              = prod_vld_reg;
    assign result.sample_out = res[15:0];
    assign result.clipped    = clip;

endmodule

@@ rtl/fir_convolution_reverb.sv @@
// Streaming direct-form FIR convolution: tap and sample memories, sequencer, output register.
// Depends on fcr_pkg and instantiates fcr_mac.
//
// A load beat writes one coefficient into the tap memory and leaves the block idle. A sample
// beat writes the sample into the history ring and then runs T multiply-accumulate steps
// through one shared multiplier, one tap a cycle, reading the tap and history memories in
// step, where T is taps_in_use capped at MAX_TAPS; the memory reads, the product and the
// sum are registered in turn, and the rounded result is loaded into the output register once
// that register is empty or its result is not stalled; the next beat is taken after that.
// Results wait in an output register while the next beat is accepted. After reset the block
// clears both memories, one entry a cycle, and accepts no beat during that pass;
// taps_in_use can be written at any idle time.
module fir_convolution_reverb #(
    parameter int MAX_TAPS    = fcr_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fcr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  fcr_pkg::req_t               req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output fcr_pkg::rsp_t               rsp_data,
    input  logic                        cfg_we,
    input  logic [fcr_pkg::TAPS_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];
    logic [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

    logic [1:0]                 state_reg, state_next;
    logic [AW-1:0]              clr_addr_reg;
    logic [AW-1:0]              wp_reg;
    logic [AW-1:0]              rd_ptr_reg;
    logic [CW-1:0]              k_reg;
    logic [CW-1:0]              n_reg;
    logic                       rd_vld_reg;
    logic [fcr_pkg::TAPS_W-1:0] taps_reg;
    logic                       rsp_valid_reg;
    fcr_pkg::rsp_t              rsp_data_reg;
    logic [SAMPLE_BITS-1:0]     tap_rd_reg;
    logic [SAMPLE_BITS-1:0]     hist_rd_reg;

    logic                   accept;
    logic                   is_load;
    logic                   is_sample;
    logic                   issue;
    logic                   rsp_take;
    logic                   rsp_load;
    logic [31:0]            tap_idx32;
    logic [31:0]            samp32;
    logic [31:0]            tap32;
    logic [31:0]            n32;
    logic [AW-1:0]          tap_addr;
    logic [SAMPLE_BITS-1:0] samp_w;
    logic [SAMPLE_BITS-1:0] tap_w;
    logic                   tap_in_range;
    logic                   mac_busy;
    fcr_pkg::mac_ctl_t      mac_ctl;
    fcr_pkg::rsp_t          mac_res;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign is_load   = accept && (req_data.req_type == fcr_pkg::REQ_LOAD);
    assign is_sample = accept && (req_data.req_type == fcr_pkg::REQ_SAMPLE);
    assign issue     = (state_reg == ST_RUN) && (k_reg != n_reg);
    assign rsp_take  = rsp_valid_reg && !rsp_stall;
    assign rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    // Field values are taken from their low SAMPLE_BITS bits, zero-padded when wider.
    assign tap_idx32    = 32'(req_data.tap_index);
    assign samp32       = 32'(unsigned'(req_data.sample_in));
    assign tap32        = 32'(unsigned'(req_data.tap_value));
    assign samp_w       = samp32[SAMPLE_BITS-1:0];
    assign tap_w        = tap32[SAMPLE_BITS-1:0];
    assign tap_addr     = tap_idx32[AW-1:0];
    assign tap_in_range = (tap_idx32 < 32'(MAX_TAPS));
    assign n32          = (32'(taps_reg) > 32'(MAX_TAPS)) ? 32'(MAX_TAPS) : 32'(taps_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (is_sample)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!issue && !rd_vld_reg && !mac_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            wp_reg        <= '0;
            rd_ptr_reg    <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            taps_reg      <= fcr_pkg::TAPS_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (cfg_we)
            begin
                taps_reg <= cfg_data;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (is_sample)
            begin
                wp_reg     <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                rd_ptr_reg <= wp_reg;
                k_reg      <= '0;
                n_reg      <= n32[CW-1:0];
            end
            else if (issue)
            begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_ADDR : rd_ptr_reg - 1'b1;
                k_reg      <= k_reg + 1'b1;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_take)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_data_reg <= mac_res;
        end
    end

    // Tap memory: written by the clearing pass or a load beat, read once per step.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            tap_mem[clr_addr_reg] <= '0;
        end
        else if (is_load && tap_in_range)
        begin
            tap_mem[tap_addr] <= tap_w;
        end
        if (issue)
        begin
            tap_rd_reg <= tap_mem[k_reg[AW-1:0]];
        end
    end

    // History ring: the new sample lands at the accept edge, before the first read.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            hist_mem[clr_addr_reg] <= '0;
        end
        else if (is_sample)
        begin
            hist_mem[wp_reg] <= samp_w;
        end
        if (issue)
        begin
            hist_rd_reg <= hist_mem[rd_ptr_reg];
        end
    end

    assign mac_ctl.clr = is_sample;
    assign mac_ctl.vld = rd_vld_reg;

    fcr_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .coef   (tap_rd_reg),
        .samp   (hist_rd_reg),
        .busy   (mac_busy),
        .result (mac_res)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

@@ rtl/fcr_checker.sv @@
// Port-level checks of the convolution reverb block, attached to it by a bind.
// Depends on fcr_pkg and on the macros in fir_convolution_reverb_macros.svh.
`include "fir_convolution_reverb_macros.svh"

module fcr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input fcr_pkg::req_t req_data,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input fcr_pkg::rsp_t rsp_data
);

    logic req_acc;
    logic load_acc;
    logic samp_acc;

    assign req_acc  = req_valid && !req_stall;
    assign load_acc = req_acc && (req_data.req_type == fcr_pkg::REQ_LOAD);
    assign samp_acc = req_acc && (req_data.req_type == fcr_pkg::REQ_SAMPLE);

    `FCR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result beat dropped while stalled")
    `FCR_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data), "stalled result changed")
    `FCR_ASSERT_NEXT(a_load_no_rsp, load_acc && !rsp_valid, !rsp_valid, "load beat produced a result")
    `FCR_ASSERT_NEXT(a_load_ready, load_acc, !req_stall, "load beat blocked the next beat")
    `FCR_ASSERT_NEXT(a_samp_busy, samp_acc, req_stall, "sample beat did not start accumulation")

endmodule

bind fir_convolution_reverb fcr_checker u_fcr_checker (.*);

@@ tb/reverb_checker.sv @@
// Checker for the convolution reverb block: watches the request, response and register ports,
// predicts each filtered sample and compares it with the block's response beat.
// Depends on fcr_pkg for the beat types, the request codes and the register width.
module reverb_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  fcr_pkg::req_t               req_data,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  fcr_pkg::rsp_t               rsp_data,
    input  logic                        cfg_we,
    input  logic [fcr_pkg::TAPS_W-1:0]  cfg_data,
    output int                          fail_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = fcr_pkg::MAX_TAPS_DEF;

    logic signed [15:0]         coef_mem [DEPTH];
    logic signed [15:0]         history  [DEPTH];
    logic [9:0]                 next_slot;
    logic [fcr_pkg::TAPS_W-1:0] taps_active;
    fcr_pkg::rsp_t              filtered_queue [$];
    fcr_pkg::rsp_t              want;
    int                         reported;

    // Exact sum of products, rounded half up by a floor shift, then saturated.
    function automatic fcr_pkg::rsp_t convolve_sample(input logic signed [15:0] x);
        longint        acc;
        longint        rounded;
        int            n;
        logic [9:0]    idx;
        fcr_pkg::rsp_t o;
        history[next_slot] = x;
        n = (taps_active > DEPTH) ? DEPTH : int'(taps_active);
        acc = 0;
        idx = next_slot;
        for (int k = 0; k < n; k++)
        begin
            acc += longint'(coef_mem[10'(k)]) * longint'(history[idx]);
            idx = (idx == '0) ? 10'(DEPTH - 1) : idx - 1'b1;
        end
        next_slot = next_slot + 1'b1;
        rounded = (acc + 64'sd16384) >>> 15;
        o.clipped = 1'b0;
        if (rounded > 32767)
        begin
            rounded = 32767;
            o.clipped = 1'b1;
        end
        else if (rounded < -32768)
        begin
            rounded = -32768;
            o.clipped = 1'b1;
        end
        o.sample_out = rounded[15:0];
        return o;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (reported < 10)
        begin
            reported++;
            $display("%t checker: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                coef_mem[i] = '0;
                history[i]  = '0;
            end
            next_slot   = '0;
            taps_active = fcr_pkg::TAPS_RESET;
            filtered_queue.delete();
            fail_count  = 0;
            reported    = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_we)
                taps_active = cfg_data;
            if (req_valid && !req_stall)
            begin
                if (req_data.req_type == fcr_pkg::REQ_LOAD)
                    coef_mem[req_data.tap_index] = req_data.tap_value;
                else
                    filtered_queue = {filtered_queue, convolve_sample(req_data.sample_in)};
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (filtered_queue.size() == 0)
                    note_failure($sformatf("unexpected beat sample_out=%0d clipped=%0b",
                                           rsp_data.sample_out, rsp_data.clipped));
                else
                begin
                    want = filtered_queue.pop_front();
                    if (want.sample_out !== rsp_data.sample_out
                        || want.clipped !== rsp_data.clipped)
                        note_failure($sformatf(
                            "expected sample_out=%0d clipped=%0b, got sample_out=%0d clipped=%0b",
                            want.sample_out, want.clipped,
                            rsp_data.sample_out, rsp_data.clipped));
                end
            end
            pending = filtered_queue.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the convolution reverb testbench: clock, reset, request and register stimulus,
// response back-pressure and the verdict. Depends on fcr_pkg, fir_convolution_reverb
// and reverb_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES = 9;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    fcr_pkg::req_t              req_data  = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    fcr_pkg::rsp_t              rsp_data;
    logic                       cfg_we    = 1'b0;
    logic [fcr_pkg::TAPS_W-1:0] cfg_data  = '0;
    int                         fail_count;
    int                         pending;
    bit                         calm      = 1'b0;
    int                         stall_left = 0;

    // Register setting per phase is drawn from [lo, hi]; the last phase runs with no idling.
    int phase_lo  [PHASES] = '{0, 1, 2047, 2, 17, 1024, 1, 5, 2};
    int phase_hi  [PHASES] = '{0, 1, 2047, 16, 300, 1024, 64, 5, 32};
    int phase_len [PHASES] = '{40, 60, 40, 80, 80, 40, 80, 80, 80};

    fir_convolution_reverb u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    reverb_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Response back-pressure in bursts of random length.
    always @(negedge clk)
    begin
        if (calm)
        begin
            stall_left = 0;
            rsp_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    function automatic fcr_pkg::req_t mk(input logic kind, input int idx, input int tv,
                                         input int s);
        fcr_pkg::req_t r;
        r.req_type  = kind;
        r.tap_index = idx[9:0];
        r.tap_value = tv[15:0];
        r.sample_in = s[15:0];
        return r;
    endfunction

    // Present one request beat, with an optional idle burst ahead of it, and hold it
    // until it is taken.
    task automatic send_beat(input fcr_pkg::req_t item);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 4);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int            taps;
        int            lim;
        int            cv;
        fcr_pkg::req_t item;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats at the reset tap count; the tap memory starts all zero.
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 1023, -32768, 32767));
        send_beat(mk(fcr_pkg::REQ_LOAD, 0, 32767, -32768));
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 0, 0, 32767));
        send_beat(mk(fcr_pkg::REQ_LOAD, 1, 32767, 0));
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 5, 77, 32767));
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 0, 0, -32768));
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 1023, 32767, -32768));
        send_beat(mk(fcr_pkg::REQ_LOAD, 1023, -32768, 32767));
        send_beat(mk(fcr_pkg::REQ_LOAD, 0, 1, 0));
        send_beat(mk(fcr_pkg::REQ_LOAD, 1, 0, 0));
        // Exactly half an LSB above and below zero rounds up.
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 0, 0, 16384));
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 0, 0, -16384));
        send_beat(mk(fcr_pkg::REQ_LOAD, 0, -32768, 0));
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 0, 0, -32768));
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 0, 0, 0));
        send_beat(mk(fcr_pkg::REQ_LOAD, 512, 12345, 32767));
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 1023, 32767, -1));
        send_beat(mk(fcr_pkg::REQ_LOAD, 2, -1, 0));
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 0, 0, 1));
        send_beat(mk(fcr_pkg::REQ_SAMPLE, 0, 0, -1));

        for (int p = 0; p < PHASES; p++)
        begin
            // The register is only written once every response is back and the last
            // load has had time to land.
            @(negedge clk);
            req_valid <= 1'b0;
            while (pending != 0)
                @(negedge clk);
            repeat (8) @(negedge clk);
            taps = $urandom_range(phase_lo[p], phase_hi[p]);
            cfg_we   <= 1'b1;
            cfg_data <= taps[fcr_pkg::TAPS_W-1:0];
            @(negedge clk);
            cfg_we <= 1'b0;
            calm = (p == PHASES - 1);
            lim = (taps > fcr_pkg::MAX_TAPS_DEF) ? fcr_pkg::MAX_TAPS_DEF : taps;

            for (int i = 0; i < phase_len[p]; i++)
            begin
                item.tap_index = 10'($urandom_range(0, 1023));
                item.tap_value = 16'($urandom);
                item.sample_in = 16'($urandom);
                if ($urandom_range(0, 99) < 35)
                begin
                    item.req_type = fcr_pkg::REQ_LOAD;
                    // Mostly aim at taps that take part in the sum.
                    if (lim > 0 && $urandom_range(0, 3) != 0)
                        item.tap_index = 10'($urandom_range(0, lim - 1));
                    case ($urandom_range(0, 9)) inside
                        0: item.tap_value = 16'sh7fff;
                        1: item.tap_value = 16'sh8000;
                        [2:3]: ;
                        default:
                        begin
                            cv = int'($urandom_range(0, 4095)) - 2048;
                            item.tap_value = cv[15:0];
                        end
                    endcase
                end
                else
                begin
                    item.req_type = fcr_pkg::REQ_SAMPLE;
                    case ($urandom_range(0, 9))
                        0: item.sample_in = 16'sh7fff;
                        1: item.sample_in = 16'sh8000;
                        2: item.sample_in = '0;
                        default: ;
                    endcase
                end
                send_beat(item);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/fcr_pkg.sv
rtl/fcr_mac.sv
rtl/fir_convolution_reverb.sv
rtl/fcr_checker.sv
tb/reverb_checker.sv
tb/testbench.sv
